// File: rtl/core/vrsp_pkg.sv
// Shared types and constants of the variable rate sample player.
// Used by vrsp_wrap, vrsp_blend and the top level under rtl/core; depends on nothing.

package vrsp_pkg;

	localparam int DEPTH         = 65536;
	localparam int ADDR_BITS     = $clog2(DEPTH);
	localparam int FRACTION_BITS = 16;
	localparam int SAMPLE_BITS   = 16;
	localparam int INT_BITS      = 16;
	localparam int PH_BITS       = INT_BITS + FRACTION_BITS;
	localparam int LEN_BITS      = 17;
	localparam int STEP_BITS     = 24;
	localparam int OPCODE_BITS   = 2;
	localparam int WRAP_BITS     = INT_BITS + 2;
	localparam int WRAP_CNT_BITS = $clog2(WRAP_BITS);
	localparam int NXT_BITS      = PH_BITS + 2;
	localparam int CRED_MAX      = 4;
	localparam int CRED_BITS     = $clog2(CRED_MAX + 1);
	localparam int FIFO_PTR_BITS = $clog2(CRED_MAX);
	localparam int TDATA_BITS    = 88;

	typedef enum logic [OPCODE_BITS-1:0] {
		OP_WRITE   = 2'd0,
		OP_PRODUCE = 2'd1,
		OP_SEEK    = 2'd2
	} opcode_t;

	typedef struct packed {
		logic                        start;
		logic signed [WRAP_BITS-1:0] value;
		logic [LEN_BITS-1:0]         len;
	} wrap_req_t;

	typedef struct packed {
		logic                done;
		logic [INT_BITS-1:0] rem;
	} wrap_rsp_t;

endpackage

// File: rtl/core/vrsp_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.

module vrsp_ram #(
	parameter int ADDR_BITS = 16,
	parameter int DATA_BITS = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] addr,
	input  logic [DATA_BITS-1:0] wdata,
	output logic [DATA_BITS-1:0] rdata
);

	logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// File: rtl/core/vrsp_wrap.sv
// Iterative playhead wrap unit: reduces a signed integer sample position
// into 0 .. length-1, one bit per cycle. Depends on vrsp_pkg.

module vrsp_wrap (
	input  logic                clk,
	input  logic                arst_n,
	input  vrsp_pkg::wrap_req_t req,
	output vrsp_pkg::wrap_rsp_t rsp
);

	typedef enum logic [1:0] {
		W_IDLE,
		W_RUN,
		W_FIN
	} wstate_t;

	wstate_t                                state_q;
	logic [vrsp_pkg::WRAP_CNT_BITS-1:0]     cnt_q;
	logic [vrsp_pkg::WRAP_BITS-1:0]         mag_q;
	logic [vrsp_pkg::LEN_BITS-1:0]          rem_q;
	logic [vrsp_pkg::LEN_BITS-1:0]          len_q;
	logic                                   neg_q;

	logic [vrsp_pkg::WRAP_BITS-1:0]         mag_start;
	logic [vrsp_pkg::LEN_BITS:0]            trial;
	logic [vrsp_pkg::LEN_BITS:0]            trial_sub;
	logic [vrsp_pkg::LEN_BITS-1:0]          rem_d;
	logic [vrsp_pkg::LEN_BITS-1:0]          len_minus;

	always_comb begin
		mag_start = req.value[vrsp_pkg::WRAP_BITS-1] ? vrsp_pkg::WRAP_BITS'(-req.value)
			: vrsp_pkg::WRAP_BITS'(req.value);
		trial     = {rem_q, mag_q[vrsp_pkg::WRAP_BITS-1]};
		trial_sub = trial - {1'b0, len_q};
		rem_d     = (trial >= {1'b0, len_q}) ? trial_sub[vrsp_pkg::LEN_BITS-1:0]
			: trial[vrsp_pkg::LEN_BITS-1:0];
		len_minus = len_q - rem_q;
	end

	always_comb begin
		rsp.done = (state_q == W_FIN);
		if (neg_q && (rem_q != '0)) begin
			rsp.rem = len_minus[vrsp_pkg::INT_BITS-1:0];
		end else begin
			rsp.rem = rem_q[vrsp_pkg::INT_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				W_IDLE: begin
					if (req.start) begin
						state_q <= W_RUN;
						cnt_q   <= '0;
					end
				end
				W_RUN: begin
					if (cnt_q == vrsp_pkg::WRAP_CNT_BITS'(vrsp_pkg::WRAP_BITS - 1)) begin
						state_q <= W_FIN;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				W_FIN: begin
					state_q <= W_IDLE;
				end
				default: begin
					state_q <= W_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == W_IDLE && req.start) begin
			mag_q <= mag_start;
			rem_q <= '0;
			len_q <= req.len;
			neg_q <= req.value[vrsp_pkg::WRAP_BITS-1];
		end else if (state_q == W_RUN) begin
			mag_q <= {mag_q[vrsp_pkg::WRAP_BITS-2:0], 1'b0};
			rem_q <= rem_d;
		end
	end

endmodule

// File: rtl/core/vrsp_blend.sv
// Two-stage linear interpolation between neighboring samples, rounding
// halves upward. Depends on vrsp_pkg.

module vrsp_blend (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	input  logic signed [vrsp_pkg::SAMPLE_BITS-1:0] a,
	input  logic signed [vrsp_pkg::SAMPLE_BITS-1:0] b,
	input  logic [vrsp_pkg::FRACTION_BITS-1:0]      frac,
	output logic                                    out_valid,
	output logic [vrsp_pkg::SAMPLE_BITS-1:0]        out_sample
);

	localparam int DIFF_BITS = vrsp_pkg::SAMPLE_BITS + 1;
	localparam int PROD_BITS = DIFF_BITS + vrsp_pkg::FRACTION_BITS + 1;

	logic signed [DIFF_BITS-1:0]               diff;
	logic signed [PROD_BITS-1:0]               prod_d;
	logic signed [PROD_BITS-1:0]               prod_s3;
	logic signed [vrsp_pkg::SAMPLE_BITS-1:0]   a_s3;
	logic                                      v_s3;
	logic signed [PROD_BITS-1:0]               rounded;
	logic [vrsp_pkg::SAMPLE_BITS-1:0]          y;

	always_comb begin
		diff    = DIFF_BITS'(b) - DIFF_BITS'(a);
		prod_d  = PROD_BITS'(diff) * PROD_BITS'($signed({1'b0, frac}));
		rounded = prod_s3 + PROD_BITS'(1 << (vrsp_pkg::FRACTION_BITS - 1));
		y       = a_s3 + rounded[vrsp_pkg::FRACTION_BITS +: vrsp_pkg::SAMPLE_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s3      <= in_valid;
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_s3    <= prod_d;
		a_s3       <= a;
		out_sample <= y;
	end

endmodule

// File: rtl/core/variable_rate_sample_player.sv
// Top level of the variable rate sample player: sample RAM, playhead,
// wrap unit, interpolator and result queue. Depends on vrsp_pkg, vrsp_ram,
// vrsp_wrap and vrsp_blend.
//
//   channel   dir  signals                       contents
//   s_axis    in   tvalid tready tdata tuser     write / produce / seek items
//   m_axis    out  tvalid tready tdata           interpolated samples
//   cfg       in   cfg_we cfg_wdata              sample_count
//
// Produce reads the single-port sample RAM twice, once for each neighbour,
// and input is held off during the second read. A step that leaves the loop
// by more than one length, or a loop shortened below the playhead, is reduced
// in the bit-serial wrap unit while input is stalled.
// Reset clears the playhead and control only; the sample RAM is not cleared.
// Up to 4 results are buffered; input stalls when all are claimed.

module variable_rate_sample_player (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// address[15:0], sample_in[31:16], step[55:32], seek_position[87:56]
	input  logic [vrsp_pkg::TDATA_BITS-1:0]     s_axis_tdata,
	// opcode[1:0]
	input  logic [vrsp_pkg::OPCODE_BITS-1:0]    s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// sample_out[15:0]
	output logic [vrsp_pkg::SAMPLE_BITS-1:0]    m_axis_tdata,
	input  logic                                cfg_we,
	input  logic [vrsp_pkg::LEN_BITS-1:0]       cfg_wdata
);

	typedef enum logic {
		ST_RUN,
		ST_WRAP
	} state_t;

	localparam int NB = vrsp_pkg::NXT_BITS;

	state_t                                   state_q;
	logic [vrsp_pkg::PH_BITS-1:0]             ph_q;
	logic [vrsp_pkg::FRACTION_BITS-1:0]       frac_q;
	logic [vrsp_pkg::LEN_BITS-1:0]            count_q;
	logic [vrsp_pkg::CRED_BITS-1:0]           cred_q;

	logic                                     v_s1;
	logic [vrsp_pkg::ADDR_BITS-1:0]           nxt_s1;
	logic [vrsp_pkg::FRACTION_BITS-1:0]       frac_s1;
	logic                                     v_s2;
	logic signed [vrsp_pkg::SAMPLE_BITS-1:0]  a_s2;
	logic [vrsp_pkg::FRACTION_BITS-1:0]       frac_s2;

	logic [vrsp_pkg::SAMPLE_BITS-1:0]         fifo_q [vrsp_pkg::CRED_MAX];
	logic [vrsp_pkg::FIFO_PTR_BITS-1:0]       wr_ptr_q;
	logic [vrsp_pkg::FIFO_PTR_BITS-1:0]       rd_ptr_q;
	logic [vrsp_pkg::CRED_BITS-1:0]           fcnt_q;

	vrsp_pkg::opcode_t                        op;
	logic [vrsp_pkg::ADDR_BITS-1:0]           address;
	logic [vrsp_pkg::SAMPLE_BITS-1:0]         sample_in;
	logic [vrsp_pkg::STEP_BITS-1:0]           step;
	logic [vrsp_pkg::PH_BITS-1:0]             seek_position;

	logic [vrsp_pkg::LEN_BITS-1:0]            len;
	logic [vrsp_pkg::LEN_BITS-1:0]            len_m1;
	logic                                     ph_over;
	logic                                     acc, acc_wr, acc_prod, acc_seek;
	logic                                     m_hs;
	logic [vrsp_pkg::INT_BITS-1:0]            idx;
	logic [vrsp_pkg::LEN_BITS-1:0]            idx_inc;
	logic [vrsp_pkg::ADDR_BITS-1:0]           nxt;
	logic signed [NB-1:0]                     nx;
	logic signed [NB-1:0]                     total;
	logic signed [NB-1:0]                     cand;
	logic                                     cand_ok;
	logic [vrsp_pkg::PH_BITS-1:0]             seek_ph;

	logic                                     ram_en;
	logic [vrsp_pkg::ADDR_BITS-1:0]           ram_addr;
	logic [vrsp_pkg::SAMPLE_BITS-1:0]         ram_rdata;

	vrsp_pkg::wrap_req_t                      wrap_req;
	vrsp_pkg::wrap_rsp_t                      wrap_rsp;

	logic                                     blend_valid;
	logic [vrsp_pkg::SAMPLE_BITS-1:0]         blend_sample;

	always_comb begin
		op            = vrsp_pkg::opcode_t'(s_axis_tuser);
		address       = s_axis_tdata[15:0];
		sample_in     = s_axis_tdata[31:16];
		step          = s_axis_tdata[55:32];
		seek_position = s_axis_tdata[87:56];

		if (count_q == '0) begin
			len = vrsp_pkg::LEN_BITS'(1);
		end else if (count_q > vrsp_pkg::LEN_BITS'(vrsp_pkg::DEPTH)) begin
			len = vrsp_pkg::LEN_BITS'(vrsp_pkg::DEPTH);
		end else begin
			len = count_q;
		end
		len_m1 = len - 1'b1;

		idx     = ph_q[vrsp_pkg::PH_BITS-1 -: vrsp_pkg::INT_BITS];
		ph_over = ({1'b0, idx} >= len);
		idx_inc = {1'b0, idx} + 1'b1;
		nxt     = (idx_inc >= len) ? '0 : idx_inc[vrsp_pkg::ADDR_BITS-1:0];

		s_axis_tready = (state_q == ST_RUN) && !v_s1 && !ph_over
			&& (cred_q < vrsp_pkg::CRED_BITS'(vrsp_pkg::CRED_MAX));
		acc      = s_axis_tvalid && s_axis_tready;
		acc_wr   = acc && (op == vrsp_pkg::OP_WRITE);
		acc_prod = acc && (op == vrsp_pkg::OP_PRODUCE);
		acc_seek = acc && (op == vrsp_pkg::OP_SEEK);
		m_hs     = m_axis_tvalid && m_axis_tready;

		nx    = $signed({2'b00, ph_q}) + NB'($signed(step));
		total = $signed({1'b0, len, {vrsp_pkg::FRACTION_BITS{1'b0}}});
		if (nx[NB-1]) begin
			cand = nx + total;
		end else if (nx >= total) begin
			cand = nx - total;
		end else begin
			cand = nx;
		end
		cand_ok = !cand[NB-1] && (cand < total);

		if ({1'b0, seek_position[vrsp_pkg::PH_BITS-1 -: vrsp_pkg::INT_BITS]} >= len) begin
			seek_ph = {len_m1[vrsp_pkg::INT_BITS-1:0], {vrsp_pkg::FRACTION_BITS{1'b0}}};
		end else begin
			seek_ph = seek_position;
		end

		wrap_req.len   = len;
		wrap_req.start = (state_q == ST_RUN) && (ph_over || (acc_prod && !cand_ok));
		if (acc_prod) begin
			wrap_req.value = nx[NB-1 -: vrsp_pkg::WRAP_BITS];
		end else begin
			wrap_req.value = $signed({2'b00, idx});
		end

		ram_en = acc_wr || acc_prod || v_s1;
		if (v_s1) begin
			ram_addr = nxt_s1;
		end else if (acc_wr) begin
			ram_addr = address;
		end else begin
			ram_addr = idx;
		end

		m_axis_tvalid = (fcnt_q != '0);
		m_axis_tdata  = fifo_q[rd_ptr_q];
	end

	vrsp_ram #(
		.ADDR_BITS(vrsp_pkg::ADDR_BITS),
		.DATA_BITS(vrsp_pkg::SAMPLE_BITS)
	) u_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (acc_wr),
		.addr (ram_addr),
		.wdata(sample_in),
		.rdata(ram_rdata)
	);

	vrsp_wrap u_wrap (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (wrap_req),
		.rsp   (wrap_rsp)
	);

	vrsp_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.a         (a_s2),
		.b         ($signed(ram_rdata)),
		.frac      (frac_s2),
		.out_valid (blend_valid),
		.out_sample(blend_sample)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			ph_q    <= '0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (acc_seek) begin
						ph_q <= seek_ph;
					end else if (acc_prod) begin
						if (cand_ok) begin
							ph_q <= cand[vrsp_pkg::PH_BITS-1:0];
						end else begin
							state_q <= ST_WRAP;
						end
					end else if (ph_over) begin
						state_q <= ST_WRAP;
					end
				end
				ST_WRAP: begin
					if (wrap_rsp.done) begin
						ph_q    <= {wrap_rsp.rem, frac_q};
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RUN) begin
			frac_q <= acc_prod ? nx[vrsp_pkg::FRACTION_BITS-1:0]
				: ph_q[vrsp_pkg::FRACTION_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= vrsp_pkg::LEN_BITS'(vrsp_pkg::DEPTH);
			cred_q   <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fcnt_q   <= '0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			cred_q <= cred_q + vrsp_pkg::CRED_BITS'(acc_prod) - vrsp_pkg::CRED_BITS'(m_hs);
			v_s1   <= acc_prod;
			v_s2   <= v_s1;
			if (blend_valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (m_hs) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fcnt_q <= fcnt_q + vrsp_pkg::CRED_BITS'(blend_valid) - vrsp_pkg::CRED_BITS'(m_hs);
		end
	end

	always_ff @(posedge clk) begin
		if (acc_prod) begin
			nxt_s1  <= nxt;
			frac_s1 <= ph_q[vrsp_pkg::FRACTION_BITS-1:0];
		end
		a_s2    <= $signed(ram_rdata);
		frac_s2 <= frac_s1;
		if (blend_valid) begin
			fifo_q[wr_ptr_q] <= blend_sample;
		end
	end

`ifndef NO_ASSERTIONS
	a_fifo_within_credit: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= cred_q)
		else $error("result queue holds more entries than claimed credits");

	a_second_read_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> !s_axis_tready)
		else $error("input accepted during second sample read");

	a_playhead_in_loop: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> ({1'b0, ph_q[vrsp_pkg::PH_BITS-1 -: vrsp_pkg::INT_BITS]} < len))
		else $error("input accepted with playhead outside loop");

	a_wrap_done_in_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		wrap_rsp.done |-> (state_q == ST_WRAP))
		else $error("wrap unit finished outside wrap state");

	a_credit_on_output: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (cred_q != '0))
		else $error("result offered without a claimed credit");
`endif

endmodule
